[src/flwk_pkg.sv]
// ----------------------------------------------------------------------------
// flwk_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package flwk_pkg;

  // Field widths.
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned VA_W    = 48;
  localparam int unsigned INDEX_W = 9;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Reset value of the physical frame mask.
  localparam logic [ADDR_W-1:0] PMASK_RESET = 64'h000F_FFFF_FFFF_F000;

  // Entry bits and address masks.
  localparam int unsigned     PRESENT_POS = 0;
  localparam int unsigned     LARGE_POS   = 7;
  localparam logic [ADDR_W-1:0] BASE_MASK   = ~64'hF;
  localparam logic [ADDR_W-1:0] GIG_FRAME   = 64'h000F_FFFF_C000_0000;
  localparam logic [ADDR_W-1:0] MEG_FRAME   = ~64'h1F_FFFF;

  // Input operation codes.
  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_REPLY     = 1'b1
  } flwk_op_t;

  // Result kinds.
  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } flwk_kind_t;

  // Walk level, one-hot. IDLE means no entry read is outstanding.
  typedef enum logic [4:0] {
    LVL_IDLE = 5'b00001,
    LVL_1    = 5'b00010,
    LVL_2    = 5'b00100,
    LVL_3    = 5'b01000,
    LVL_4    = 5'b10000
  } flwk_lvl_t;

  // One classified item as it travels from the front to the back.
  // For a translate request, word holds the cleaned table base;
  // for a memory reply, word holds the returned entry.
  typedef struct packed {
    flwk_op_t          op;
    logic [ADDR_W-1:0] word;
    logic [VA_W-1:0]   vaddr;
  } flwk_item_t;

endpackage

[src/flwk_front.sv]
// ----------------------------------------------------------------------------
// flwk_front
// Input stage: accepts words, classifies them and registers the item.
// ----------------------------------------------------------------------------
module flwk_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [63:0]          in_dir_base,
  input  logic [47:0]          in_vaddr,
  input  logic [63:0]          in_read_data,
  output logic                 item_valid,
  input  logic                 item_ready,
  output flwk_pkg::flwk_item_t item
);
  import flwk_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  flwk_item_t item_r;
  flwk_item_t item_nxt;
  logic       take;

  // The stage takes a new word when it is empty or its item moves on.
  assign in_ready = !valid_r || item_ready;
  assign take     = in_valid && in_ready;

  // Classify: a request keeps the cleaned base, a reply keeps the entry.
  always_comb begin
    item_nxt       = item_r;
    item_nxt.op    = flwk_op_t'(in_op);
    item_nxt.vaddr = in_vaddr;
    if (flwk_op_t'(in_op) == OP_TRANSLATE) begin
      item_nxt.word = in_dir_base & BASE_MASK;
    end else begin
      item_nxt.word = in_read_data;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[src/flwk_queue.sv]
// ----------------------------------------------------------------------------
// flwk_queue
// Short FIFO between the front and back parts so each can stall alone.
// ----------------------------------------------------------------------------
module flwk_queue #(
  parameter int unsigned DEPTH = flwk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  flwk_pkg::flwk_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output flwk_pkg::flwk_item_t pop_item
);
  import flwk_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  flwk_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[src/flwk_back.sv]
// ----------------------------------------------------------------------------
// flwk_back
// Walk engine: steps one item per cycle unless its held result is stalled.
// ----------------------------------------------------------------------------
module flwk_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [63:0]          cfg_wr_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  flwk_pkg::flwk_item_t item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_kind,
  output logic [63:0]          out_addr,
  output logic                 out_not_mapped
);
  import flwk_pkg::*;

  logic [ADDR_W-1:0] pmask_r;
  flwk_lvl_t         lvl_r;
  flwk_lvl_t         lvl_nxt;
  logic [VA_W-1:0]   vaddr_r;
  logic [VA_W-1:0]   vaddr_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  flwk_kind_t        kind_r;
  flwk_kind_t        kind_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] addr_nxt;
  logic              nm_r;
  logic              nm_nxt;
  logic              emit;
  logic              step;
  logic [ADDR_W-1:0] entry;
  logic [ADDR_W-1:0] frame;
  logic              present;
  logic              big_page;

  // An item moves in when the result register is free or being emptied.
  assign item_ready = !out_valid_r || out_ready;
  assign step       = item_valid && item_ready;

  assign entry    = item.word;
  assign frame    = entry & pmask_r;
  assign present  = entry[PRESENT_POS];
  assign big_page = entry[LARGE_POS];

  // One walk step for the item at the head of the queue.
  always_comb begin
    lvl_nxt   = lvl_r;
    vaddr_nxt = vaddr_r;
    emit      = 1'b0;
    kind_nxt  = kind_r;
    addr_nxt  = addr_r;
    nm_nxt    = 1'b0;
    if (item.op == OP_TRANSLATE) begin
      // A request starts a walk only when none is running.
      if (lvl_r == LVL_IDLE) begin
        vaddr_nxt = item.vaddr;
        lvl_nxt   = LVL_4;
        emit      = 1'b1;
        kind_nxt  = KIND_READ;
        addr_nxt  = item.word + {52'd0, item.vaddr[47:39], 3'd0};
      end
    end else begin
      case (lvl_r)
        LVL_4: begin
          emit = 1'b1;
          if (!present) begin
            lvl_nxt  = LVL_IDLE;
            kind_nxt = KIND_DONE;
            addr_nxt = '0;
            nm_nxt   = 1'b1;
          end else begin
            lvl_nxt  = LVL_3;
            kind_nxt = KIND_READ;
            addr_nxt = frame + {52'd0, vaddr_r[38:30], 3'd0};
          end
        end
        LVL_3: begin
          emit = 1'b1;
          if (!present) begin
            lvl_nxt  = LVL_IDLE;
            kind_nxt = KIND_DONE;
            addr_nxt = '0;
            nm_nxt   = 1'b1;
          end else if (big_page) begin
            // 1 GB page.
            lvl_nxt  = LVL_IDLE;
            kind_nxt = KIND_DONE;
            addr_nxt = (entry & GIG_FRAME) + {34'd0, vaddr_r[29:0]};
          end else begin
            lvl_nxt  = LVL_2;
            kind_nxt = KIND_READ;
            addr_nxt = frame + {52'd0, vaddr_r[29:21], 3'd0};
          end
        end
        LVL_2: begin
          emit = 1'b1;
          if (!present) begin
            lvl_nxt  = LVL_IDLE;
            kind_nxt = KIND_DONE;
            addr_nxt = '0;
            nm_nxt   = 1'b1;
          end else if (big_page) begin
            // 2 MB page.
            lvl_nxt  = LVL_IDLE;
            kind_nxt = KIND_DONE;
            addr_nxt = (frame & MEG_FRAME) + {43'd0, vaddr_r[20:0]};
          end else begin
            lvl_nxt  = LVL_1;
            kind_nxt = KIND_READ;
            addr_nxt = frame + {52'd0, vaddr_r[20:12], 3'd0};
          end
        end
        LVL_1: begin
          // The last level checks only for a nonzero frame.
          emit     = 1'b1;
          lvl_nxt  = LVL_IDLE;
          kind_nxt = KIND_DONE;
          if (frame == '0) begin
            addr_nxt = '0;
            nm_nxt   = 1'b1;
          end else begin
            addr_nxt = frame + {52'd0, vaddr_r[11:0]};
          end
        end
        default: begin
          // A reply with no walk running is dropped.
          lvl_nxt = LVL_IDLE;
        end
      endcase
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and the frame mask register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r       <= LVL_IDLE;
      vaddr_r     <= '0;
      out_valid_r <= 1'b0;
      pmask_r     <= PMASK_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        lvl_r   <= lvl_nxt;
        vaddr_r <= vaddr_nxt;
      end
      if (cfg_wr_en) begin
        pmask_r <= cfg_wr_data;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (step && emit) begin
      kind_r <= kind_nxt;
      addr_r <= addr_nxt;
      nm_r   <= nm_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_addr       = addr_r;
  assign out_not_mapped = nm_r;

endmodule

[src/four_level_page_walker.sv]
// ----------------------------------------------------------------------------
// four_level_page_walker
// Four-level page table walker driven by requests and memory replies.
// ----------------------------------------------------------------------------
// A translate request (tuser 0) carries the top-level table base and a 48-bit
// virtual address; the block answers with an entry read request (tuser 0 on
// the output), and each memory reply fed back in (tuser 1) yields the next
// read or the finished translation (tuser 1 on the output) for a 4 KB, 2 MB
// or 1 GB page, or a not-mapped answer with address 0. Requests that arrive
// during a walk and replies that arrive with no walk running are dropped
// without a result. The block takes one word per cycle unless the output
// stalls; the walk engine handles each word with one 64-bit add, and a
// word passes through the input register, queue and result register. The
// user must write the physical frame mask through cfg_wr_en and cfg_wr_data
// only while the block is idle; the block itself does not enforce it.
module four_level_page_walker #(
  parameter int unsigned QUEUE_DEPTH = flwk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // Configuration: physical frame mask.
  input  logic          cfg_wr_en,
  input  logic [63:0]   cfg_wr_data,
  // Input channel.
  input  logic          in_tvalid,
  output logic          in_tready,
  // tdata: dir_base [63:0], virtual_address [111:64], read_data [175:112].
  input  logic [175:0]  in_tdata,
  // tuser: operation.
  input  logic          in_tuser,
  // Result channel.
  output logic          out_tvalid,
  input  logic          out_tready,
  // tdata: out_address [63:0], not_mapped [64], zero fill [71:65].
  output logic [71:0]   out_tdata,
  // tuser: result_kind.
  output logic          out_tuser
);
  import flwk_pkg::*;

  flwk_item_t        front_item;
  logic              front_valid;
  logic              front_ready;
  flwk_item_t        head_item;
  logic              head_valid;
  logic              head_ready;
  logic [ADDR_W-1:0] res_addr;
  logic              res_nm;

  // Front part: accept and classify.
  flwk_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (in_tuser),
    .in_dir_base  (in_tdata[63:0]),
    .in_vaddr     (in_tdata[111:64]),
    .in_read_data (in_tdata[175:112]),
    .item_valid   (front_valid),
    .item_ready   (front_ready),
    .item         (front_item)
  );

  // Queue between the two parts.
  flwk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_item   (head_item)
  );

  // Back part: walk engine and result register.
  flwk_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .item_valid     (head_valid),
    .item_ready     (head_ready),
    .item           (head_item),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_kind       (out_tuser),
    .out_addr       (res_addr),
    .out_not_mapped (res_nm)
  );

  // Pack the result word.
  assign out_tdata = {7'd0, res_nm, res_addr};

endmodule
